/* hdl/csb_pkg.sv */
// Package of the clipped sprite blitter: sizes, register indexes, item and
// status types. Used by every other file of the block; depends on nothing.
package csb_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int PIXEL_BITS    = 32;

  localparam int POS_W    = 16;
  localparam int SIZE_W   = 13;
  localparam int SCREEN_W = 13;
  localparam int COLOR_W  = 32;
  localparam int ADDR_W   = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int DIM_W = CNT_W + 1;

  localparam logic [COLOR_W-1:0] COLOR_MASK = COLOR_W'((64'd1 << PIXEL_BITS) - 64'd1);

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = SCREEN_W'(640);
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = SCREEN_W'(480);
  localparam logic [COLOR_W-1:0]  TRANSPARENT_KEY_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH    = 2'd0,
    REG_SCREEN_HEIGHT   = 2'd1,
    REG_TRANSPARENT_KEY = 2'd2
  } csb_reg_e;

  typedef enum logic {
    ACT_SETUP = 1'b0,
    ACT_PIXEL = 1'b1
  } csb_action_e;

  typedef struct packed {
    logic                     action;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        sprite_width;
    logic [SIZE_W-1:0]        sprite_height;
    logic                     top_down;
    logic                     shader_mode;
    logic [COLOR_W-1:0]       fill_color;
    logic [COLOR_W-1:0]       source_pixel;
  } csb_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_color;
  } csb_out_t;

  typedef struct packed {
    logic              active;
    logic [DIM_W-1:0]  sprite_width;
    logic [DIM_W-1:0]  clip_columns;
    logic [DIM_W-1:0]  clip_rows;
    logic [ADDR_W-1:0] row_base_address;
  } csb_setup_t;

endpackage

/* hdl/csb_if.sv */
// Valid/ready channel interfaces of the clipped sprite blitter.
// Depends on csb_pkg for the payload types.
interface csb_in_if;
  logic            valid;
  logic            ready;
  csb_pkg::csb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csb_out_if;
  logic             valid;
  logic             ready;
  csb_pkg::csb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/clipped_sprite_blit.sv */
// Top level of the clipped sprite blitter: configuration registers, input
// register and the engine. Depends on csb_pkg, csb_if, csb_setup, csb_engine.
//
// Usage:
//   item_i carries setup items (action 0) and sprite pixels (action 1) in
//   raster order; result_o carries framebuffer writes (address, color).
//   A transfer on item_i lands in an input register; from there the setup
//   geometry or the pixel clipping is worked out and any write is placed in
//   the result register, which offers it on result_o. One item is taken
//   every cycle, as long as result_o takes its writes; the rate is set by
//   the single pass from the input register through the 13 x 13 row address
//   multiplier to the state. Setups, clipped pixels and transparent pixels
//   give no write. When result_o stalls with a write pending, the input
//   register can still hold one more item; item_i.ready stays low until the
//   write leaves. The user must write configuration (cfg_we_i, cfg_index_i,
//   cfg_data_i) only while no item is in flight; the block does not enforce
//   this. Reset empties both registers, ends any blit and restores the screen
//   size to 640 x 480 and the transparent key to zero.
module clipped_sprite_blit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [csb_pkg::CFG_W-1:0]       cfg_data_i,
  csb_in_if.sink                          item_i,
  csb_out_if.source                       result_o
);

  logic [csb_pkg::SCREEN_W-1:0] screen_width_q;
  logic [csb_pkg::SCREEN_W-1:0] screen_height_q;
  logic [csb_pkg::COLOR_W-1:0]  transparent_key_q;
  logic                         stage_valid_q, stage_valid_d;
  csb_pkg::csb_in_t             stage_data_q;
  logic                         take;
  csb_pkg::csb_setup_t          setup;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q    <= csb_pkg::SCREEN_WIDTH_RESET;
      screen_height_q   <= csb_pkg::SCREEN_HEIGHT_RESET;
      transparent_key_q <= csb_pkg::TRANSPARENT_KEY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        csb_pkg::REG_SCREEN_WIDTH: begin
          screen_width_q <= cfg_data_i[csb_pkg::SCREEN_W-1:0];
        end
        csb_pkg::REG_SCREEN_HEIGHT: begin
          screen_height_q <= cfg_data_i[csb_pkg::SCREEN_W-1:0];
        end
        csb_pkg::REG_TRANSPARENT_KEY: begin
          transparent_key_q <= cfg_data_i[csb_pkg::COLOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign item_i.ready = !stage_valid_q || take;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (take) begin
      stage_valid_d = 1'b0;
    end
    if (item_i.valid && item_i.ready) begin
      stage_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      stage_data_q <= item_i.data;
    end
  end

  csb_setup u_setup (
    .item_i          (stage_data_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .setup_o         (setup)
  );

  csb_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stage_valid_i     (stage_valid_q),
    .stage_data_i      (stage_data_q),
    .setup_i           (setup),
    .screen_width_i    (screen_width_q),
    .transparent_key_i (transparent_key_q),
    .take_o            (take),
    .result_o          (result_o)
  );

endmodule

/* hdl/csb_setup.sv */
// Blit geometry of a setup item: top-down adjust, drop test, clamping,
// clip extents and first row address. Combinational; depends on csb_pkg.
module csb_setup (
  input  csb_pkg::csb_in_t                 item_i,
  input  logic [csb_pkg::SCREEN_W-1:0]     screen_width_i,
  input  logic [csb_pkg::SCREEN_W-1:0]     screen_height_i,
  output csb_pkg::csb_setup_t              setup_o
);

  logic [csb_pkg::DIM_W-1:0]    w_cl;
  logic [csb_pkg::DIM_W-1:0]    h_cl;
  logic [csb_pkg::DIM_W-1:0]    h_lift;
  logic signed [17:0]           x_ext;
  logic signed [17:0]           y_adj;
  logic signed [17:0]           sw_s;
  logic signed [17:0]           sh_s;
  logic                         drop;
  logic [csb_pkg::SCREEN_W-1:0] x_cl;
  logic [csb_pkg::SCREEN_W-1:0] y_cl;
  logic [csb_pkg::SCREEN_W-1:0] room_x;
  logic [csb_pkg::SCREEN_W-1:0] room_y;
  logic [csb_pkg::DIM_W-1:0]    clip_c;
  logic [csb_pkg::DIM_W-1:0]    clip_r;
  logic [2*csb_pkg::SCREEN_W-1:0] prod;

  always_comb begin
    w_cl = (32'(item_i.sprite_width) > 32'(csb_pkg::MAX_DIMENSION)) ?
           csb_pkg::DIM_W'(csb_pkg::MAX_DIMENSION) : csb_pkg::DIM_W'(item_i.sprite_width);
    h_cl = (32'(item_i.sprite_height) > 32'(csb_pkg::MAX_DIMENSION)) ?
           csb_pkg::DIM_W'(csb_pkg::MAX_DIMENSION) : csb_pkg::DIM_W'(item_i.sprite_height);
    h_lift = (item_i.top_down && (h_cl != '0)) ? h_cl - csb_pkg::DIM_W'(1) : '0;

    x_ext = 18'(item_i.pos_x);
    y_adj = 18'(item_i.pos_y) - $signed(18'(h_lift));
    sw_s  = $signed(18'(screen_width_i));
    sh_s  = $signed(18'(screen_height_i));
    drop  = (y_adj >= sh_s) || (x_ext >= sw_s);

    x_cl = x_ext[17] ? '0 : x_ext[csb_pkg::SCREEN_W-1:0];
    y_cl = y_adj[17] ? '0 : y_adj[csb_pkg::SCREEN_W-1:0];
    room_x = screen_width_i - x_cl;
    room_y = screen_height_i - y_cl;
    clip_c = (32'(w_cl) < 32'(room_x)) ? w_cl : csb_pkg::DIM_W'(room_x);
    clip_r = (32'(h_cl) < 32'(room_y)) ? h_cl : csb_pkg::DIM_W'(room_y);
    prod   = (2*csb_pkg::SCREEN_W)'(y_cl) * (2*csb_pkg::SCREEN_W)'(screen_width_i);

    setup_o.sprite_width = w_cl;
    if (drop) begin
      setup_o.active           = 1'b0;
      setup_o.clip_columns     = '0;
      setup_o.clip_rows        = '0;
      setup_o.row_base_address = '0;
    end else begin
      setup_o.active           = (clip_c != '0) && (clip_r != '0);
      setup_o.clip_columns     = clip_c;
      setup_o.clip_rows        = clip_r;
      setup_o.row_base_address = csb_pkg::ADDR_W'(prod + (2*csb_pkg::SCREEN_W)'(x_cl));
    end
  end

endmodule

/* hdl/csb_engine.sv */
// Blit state, per-pixel clipping and keying, and the result register.
// Depends on csb_pkg, csb_if and the geometry from csb_setup.
module csb_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          stage_valid_i,
  input  csb_pkg::csb_in_t              stage_data_i,
  input  csb_pkg::csb_setup_t           setup_i,
  input  logic [csb_pkg::SCREEN_W-1:0]  screen_width_i,
  input  logic [csb_pkg::COLOR_W-1:0]   transparent_key_i,
  output logic                          take_o,
  csb_out_if.source                     result_o
);

  logic                         active_q, active_d;
  logic [csb_pkg::CNT_W-1:0]    col_q, col_d;
  logic [csb_pkg::CNT_W-1:0]    row_q, row_d;
  logic [csb_pkg::DIM_W-1:0]    clip_cols_q, clip_cols_d;
  logic [csb_pkg::DIM_W-1:0]    clip_rows_q, clip_rows_d;
  logic [csb_pkg::ADDR_W-1:0]   base_q, base_d;
  logic [csb_pkg::DIM_W-1:0]    saved_w_q, saved_w_d;
  logic                         mode_q, mode_d;
  logic [csb_pkg::COLOR_W-1:0]  color_q, color_d;
  logic                         out_valid_q, out_valid_d;
  csb_pkg::csb_out_t            out_data_q;

  logic                         is_pixel;
  logic [csb_pkg::COLOR_W-1:0]  pix;
  logic [csb_pkg::DIM_W-1:0]    col_inc;
  logic [csb_pkg::DIM_W-1:0]    row_inc;
  logic                         row_end;
  logic                         emit;
  csb_pkg::csb_out_t            result;

  assign take_o   = stage_valid_i && (!out_valid_q || result_o.ready);
  assign is_pixel = (stage_data_i.action == csb_pkg::ACT_PIXEL);
  assign pix      = stage_data_i.source_pixel & csb_pkg::COLOR_MASK;
  assign col_inc  = csb_pkg::DIM_W'(col_q) + csb_pkg::DIM_W'(1);
  assign row_inc  = csb_pkg::DIM_W'(row_q) + csb_pkg::DIM_W'(1);
  assign row_end  = (col_inc >= saved_w_q);
  assign emit     = is_pixel && active_q && (csb_pkg::DIM_W'(col_q) < clip_cols_q) &&
                    (pix != (transparent_key_i & csb_pkg::COLOR_MASK));

  assign result.write_address = base_q + csb_pkg::ADDR_W'(col_q);
  assign result.write_color   = mode_q ? color_q : pix;

  always_comb begin
    active_d    = active_q;
    col_d       = col_q;
    row_d       = row_q;
    clip_cols_d = clip_cols_q;
    clip_rows_d = clip_rows_q;
    base_d      = base_q;
    saved_w_d   = saved_w_q;
    mode_d      = mode_q;
    color_d     = color_q;
    if (take_o) begin
      if (!is_pixel) begin
        active_d    = setup_i.active;
        col_d       = '0;
        row_d       = '0;
        clip_cols_d = setup_i.clip_columns;
        clip_rows_d = setup_i.clip_rows;
        base_d      = setup_i.row_base_address;
        saved_w_d   = setup_i.sprite_width;
        mode_d      = stage_data_i.shader_mode;
        color_d     = stage_data_i.fill_color & csb_pkg::COLOR_MASK;
      end else if (active_q) begin
        if (row_end) begin
          col_d  = '0;
          row_d  = row_inc[csb_pkg::CNT_W-1:0];
          base_d = base_q + csb_pkg::ADDR_W'(screen_width_i);
          if (row_inc >= clip_rows_q) begin
            active_d = 1'b0;
          end
        end else begin
          col_d = col_inc[csb_pkg::CNT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      clip_cols_q <= '0;
      clip_rows_q <= '0;
      base_q      <= '0;
      saved_w_q   <= '0;
      mode_q      <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      col_q       <= col_d;
      row_q       <= row_d;
      clip_cols_q <= clip_cols_d;
      clip_rows_q <= clip_rows_d;
      base_q      <= base_d;
      saved_w_q   <= saved_w_d;
      mode_q      <= mode_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_data_q <= result;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // The column count always stays below the sprite width of a running blit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (csb_pkg::DIM_W'(col_q) < saved_w_q))
    else $error("column count reached sprite width during a blit");

  // A running blit has a visible area and has not passed its last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((clip_cols_q != '0) && (csb_pkg::DIM_W'(row_q) < clip_rows_q)))
    else $error("blit active outside its clipped area");

  // A setup transfer restarts the sprite at its first pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !is_pixel) |=> ((col_q == '0) && (row_q == '0)))
    else $error("setup did not restart the counters");

  // A result is only loaded when the result register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !take_o)
    else $error("item taken while a result is stalled");

endmodule

/* tb/clipped_sprite_blit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the clipped sprite blitter: directed and random setups and
// sprite pixels, a bursty sender, a stalling receiver and an in-order framebuffer write
// predictor. Depends on csb_pkg, csb_if and the clipped_sprite_blit top level.
module clipped_sprite_blit_test;
  import csb_pkg::*;

  localparam int IN_BITS        = $bits(csb_in_t);
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_stall_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  csb_in_if  item_if ();
  csb_out_if result_if ();

  clipped_sprite_blit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Screen registers and blit state as the block should hold them.
  logic [SCREEN_W-1:0] scr_w = SCREEN_WIDTH_RESET;
  logic [SCREEN_W-1:0] scr_h = SCREEN_HEIGHT_RESET;
  logic [COLOR_W-1:0]  key_color = TRANSPARENT_KEY_RESET;
  logic                blit_on = 1'b0;
  logic [DIM_W-1:0]    col_idx = '0;
  logic [DIM_W-1:0]    row_idx = '0;
  logic [DIM_W-1:0]    visible_cols = '0;
  logic [DIM_W-1:0]    visible_rows = '0;
  logic [ADDR_W-1:0]   line_base = '0;
  logic [DIM_W-1:0]    sprite_w = '0;
  logic                paint_mode = 1'b0;
  logic [COLOR_W-1:0]  paint_color = '0;

  csb_in_t   queued_items[$];
  csb_out_t  pending_fb_writes[$];
  csb_out_t  predicted_write;
  csb_out_t  oldest_write;

  rx_stall_e rx_mode = RX_ALWAYS;
  int        gap_max = 0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        stall_tick = 0;
  int        idle_cycles = 0;
  logic      watchdog_fired = 1'b0;
  int        mismatch_count = 0;
  int        items_transferred = 0;
  int        writes_checked = 0;
  int        stimulus_items = 0;
  int        settings_run = 0;

  function automatic int dim_clamp(logic [SIZE_W-1:0] s);
    return (s > MAX_DIMENSION) ? MAX_DIMENSION : int'(s);
  endfunction

  // Advances the blit state by one transferred item; returns 1 when it writes a pixel.
  function automatic bit compute_framebuffer_write(csb_in_t it, output csb_out_t wr);
    int  x, y, w, h;
    bit  hit;
    wr  = '0;
    hit = 1'b0;
    if (it.action == ACT_SETUP) begin
      x = $signed(it.pos_x);
      y = $signed(it.pos_y);
      w = dim_clamp(it.sprite_width);
      h = dim_clamp(it.sprite_height);
      if (it.top_down && h > 0) y = y - (h - 1);
      blit_on     = 1'b0;
      col_idx     = '0;
      row_idx     = '0;
      sprite_w    = DIM_W'(w);
      paint_mode  = it.shader_mode;
      paint_color = it.fill_color & COLOR_MASK;
      if (y >= int'(scr_h) || x >= int'(scr_w)) begin
        visible_cols = '0;
        visible_rows = '0;
        line_base    = '0;
      end else begin
        if (y < 0) y = 0;
        if (x < 0) x = 0;
        visible_cols = DIM_W'((w < int'(scr_w) - x) ? w : int'(scr_w) - x);
        visible_rows = DIM_W'((h < int'(scr_h) - y) ? h : int'(scr_h) - y);
        line_base    = ADDR_W'(y * int'(scr_w) + x);
        blit_on      = (visible_cols != 0) && (visible_rows != 0);
      end
    end else if (blit_on) begin
      if (col_idx < visible_cols &&
          (it.source_pixel & COLOR_MASK) != (key_color & COLOR_MASK)) begin
        wr.write_address = line_base + ADDR_W'(col_idx);
        wr.write_color   = paint_mode ? paint_color : (it.source_pixel & COLOR_MASK);
        hit = 1'b1;
      end
      col_idx = col_idx + DIM_W'(1);
      if (col_idx >= sprite_w) begin
        col_idx   = '0;
        row_idx   = row_idx + DIM_W'(1);
        line_base = line_base + ADDR_W'(scr_w);
        if (row_idx >= visible_rows) blit_on = 1'b0;
      end
    end
    return hit;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        items_transferred++;
        if (compute_framebuffer_write(item_if.data, predicted_write))
          pending_fb_writes.push_back(predicted_write);
      end
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (queued_items.size() > 0) begin
          item_if.valid <= 1'b1;
          item_if.data  <= queued_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served    <= holds_served + 1;
      hold_left       <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      case (rx_mode)
        RX_ALWAYS:   result_if.ready <= 1'b1;
        RX_RANDOM:   result_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: result_if.ready <= ((stall_tick % 5) < 3);
        default:     result_if.ready <= ($urandom_range(0, 4) < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      writes_checked++;
      if (pending_fb_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < 40)
          $display("%0t: unexpected write, expected none, actual address %h color %h",
                   $time, result_if.data.write_address, result_if.data.write_color);
      end else begin
        oldest_write = pending_fb_writes.pop_front();
        if (result_if.data.write_address != oldest_write.write_address) begin
          mismatch_count++;
          if (mismatch_count < 40)
            $display("%0t: write_address mismatch, expected %h, actual %h", $time,
                     oldest_write.write_address, result_if.data.write_address);
        end
        if (result_if.data.write_color != oldest_write.write_color) begin
          mismatch_count++;
          if (mismatch_count < 40)
            $display("%0t: write_color mismatch, expected %h, actual %h", $time,
                     oldest_write.write_color, result_if.data.write_color);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles <= 0;
      else if (idle_cycles == WATCHDOG_LIMIT)
        watchdog_fired <= 1'b1;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic csb_in_t random_item();
    return IN_BITS'({$urandom(), $urandom(), $urandom(), $urandom()});
  endfunction

  task automatic push_item(csb_in_t it);
    queued_items.push_back(it);
    stimulus_items++;
  endtask

  task automatic add_setup(int x, int y, int w, int h, bit td, bit shade,
                           logic [COLOR_W-1:0] color);
    csb_in_t it;
    it               = random_item();
    it.action        = ACT_SETUP;
    it.pos_x         = x[POS_W-1:0];
    it.pos_y         = y[POS_W-1:0];
    it.sprite_width  = w[SIZE_W-1:0];
    it.sprite_height = h[SIZE_W-1:0];
    it.top_down      = td;
    it.shader_mode   = shade;
    it.fill_color    = color;
    push_item(it);
  endtask

  task automatic add_pixel(logic [COLOR_W-1:0] color);
    csb_in_t it;
    it              = random_item();
    it.action       = ACT_PIXEL;
    it.source_pixel = color;
    push_item(it);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    return ($urandom_range(0, 5) == 0) ? key_color : COLOR_W'($urandom());
  endfunction

  // Coordinates clustered around both screen edges, with some anywhere in range.
  function automatic int edge_coord(int size, int limit);
    case ($urandom_range(0, 4))
      0:       return 0 - int'($urandom_range(0, size + 2));
      1:       return $urandom_range(0, limit);
      2:       return limit - int'($urandom_range(0, size + 1));
      3:       return int'($urandom_range(0, 65535)) - 32768;
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  function automatic int random_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(0, 8191);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic add_random_blit();
    int w, h, n, shown;
    w = random_size();
    h = random_size();
    add_setup(edge_coord(w, int'(scr_w)), edge_coord(h, int'(scr_h)), w, h,
              $urandom_range(0, 1), $urandom_range(0, 1), $urandom());
    shown = dim_clamp(w[SIZE_W-1:0]) * dim_clamp(h[SIZE_W-1:0]);
    if (shown > 40) shown = 40;
    n = ($urandom_range(0, 9) < 7) ? shown + $urandom_range(0, 2) : $urandom_range(0, shown);
    repeat (n) add_pixel(pick_color());
  endtask

  // Stray pixels and fully random setups, kept out of the item count.
  task automatic add_noise();
    csb_in_t it;
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) begin
        it        = random_item();
        it.action = ACT_PIXEL;
        queued_items.push_back(it);
      end
    end else begin
      it        = random_item();
      it.action = ACT_SETUP;
      queued_items.push_back(it);
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || item_if.valid || pending_fb_writes.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(csb_reg_e idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = value[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: scr_h = value[SCREEN_W-1:0];
      default:           key_color = value;
    endcase
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(int w, int h, logic [COLOR_W-1:0] key, rx_stall_e rx,
                           int gaps, int target, bit hold);
    int start;
    settle();
    write_reg(REG_SCREEN_WIDTH, {19'($urandom()), w[SCREEN_W-1:0]});
    write_reg(REG_SCREEN_HEIGHT, {19'($urandom()), h[SCREEN_W-1:0]});
    write_reg(REG_TRANSPARENT_KEY, key);
    rx_mode = rx;
    gap_max = gaps;
    settings_run++;
    start = stimulus_items;
    while (stimulus_items - start < target) begin
      if ($urandom_range(0, 6) == 0) add_noise();
      else add_random_blit();
    end
    if (hold) hold_requests++;
  endtask

  task automatic run_all();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    rx_mode = RX_PERIODIC;
    gap_max = 2;
    settings_run++;

    add_pixel(32'h1234_5678);
    add_setup(-2, -1, 3, 2, 1'b0, 1'b0, 32'h0);
    add_pixel(32'hFFFF_FFFF);
    add_pixel(32'h0000_0000);
    add_pixel(32'h8000_0001);
    add_pixel(32'h0000_0001);
    add_pixel(32'hDEAD_BEEF);
    add_pixel(32'h7FFF_FFFF);
    add_setup(637, 479, 4, 2, 1'b1, 1'b1, 32'hA5A5_5A5A);
    repeat (9) add_pixel($urandom());
    add_setup(32767, 0, 2, 2, 1'b0, 1'b0, 32'h0);
    add_pixel(32'h0000_00FF);
    add_setup(10, 10, 0, 3, 1'b0, 1'b0, 32'h0);
    add_pixel(32'h0000_FF00);
    add_setup(-32768, -32768, 8191, 8191, 1'b0, 1'b1, 32'hFFFF_FFFF);
    add_pixel(32'h00FF_0000);
    add_pixel(32'h0F0F_0F0F);

    // The next row start must pick up a screen width written in mid-blit.
    settle();
    add_setup(5, 5, 2, 3, 1'b0, 1'b0, 32'h0);
    add_pixel(32'h1111_1111);
    add_pixel(32'h2222_2222);
    settle();
    write_reg(REG_SCREEN_WIDTH, 32'd100);
    repeat (4) add_pixel($urandom());

    run_phase(640, 480, $urandom(), RX_RANDOM, 4, 300, 1'b1);
    run_phase(16, 12, 32'hFFFF_FFFF, RX_PERIODIC, 0, 300, 1'b0);
    run_phase(1, 1, 32'h0, RX_ALWAYS, 3, 150, 1'b0);
    run_phase(4096, 4096, $urandom(), RX_HEAVY, 2, 300, 1'b1);
    run_phase(8191, 8191, $urandom(), RX_RANDOM, 0, 250, 1'b0);
    run_phase(0, 7, $urandom(), RX_RANDOM, 2, 100, 1'b0);
    run_phase(9, 0, $urandom(), RX_HEAVY, 1, 100, 1'b0);
    run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom(), RX_ALWAYS, 0, 420,
              1'b0);
    settle();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    if (pending_fb_writes.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d writes expected, actual none arrived", $time,
               pending_fb_writes.size());
    end
  endtask

  initial begin
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    result_if.ready = 1'b0;
    fork
      run_all();
      wait (watchdog_fired);
    join_any
    if (watchdog_fired) $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Ran %0d item transfers over %0d screen settings, with clipping, transparency,",
             items_transferred, settings_run);
    $display("both shaders and receiver hold-offs; %0d framebuffer writes checked.",
             writes_checked);
    if (!watchdog_fired && mismatch_count == 0) $display("[clipped_sprite_blit] OK");
    else $display("[clipped_sprite_blit] ERROR");
    $finish;
  end

endmodule
